FILE: hw/rtl/psx_pkg.sv
// ----------------------------------------------------------------------------
// psx_pkg
// Shared constants and controller/datapath signal groups for the point sorter.
// ----------------------------------------------------------------------------
package psx_pkg;

    localparam int MAX_POINTS_DEF = 64;
    localparam int COORD_BITS_DEF = 16;

    // controller -> datapath
    typedef struct packed {
        logic load;        // capture request, set up insert position
        logic rd_prev;     // read entry below insert position
        logic shift;       // move read entry up one slot
        logic place;       // write new point at insert position
        logic emit_start;  // rewind output index
        logic emit_rd;     // read next entry for output
        logic emit_out;    // present read entry on result ports
        logic clear;       // empty the store for the next set
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic full;
        logic pos_zero;
        logic prev_gt;
        logic last;
        logic emit_done;
    } t_status;

endpackage

FILE: hw/rtl/point_sort_by_x.sv
// ----------------------------------------------------------------------------
// point_sort_by_x
// Collects a set of signed 2D points and returns them sorted by ascending x.
// ----------------------------------------------------------------------------
// Usage: present a point on i_point_x/i_point_y/i_last_point with start high;
// the request is taken at a rising edge where start is high and busy is low.
// Each point is insertion-sorted into an on-chip store (stable for equal x):
// it is loaded, each stored entry with greater x is read and moved up one slot
// through the single read port of the store, and the point is then placed at
// the slot where the walk stops. A point arriving when MAX_POINTS are already
// held is dropped and the set is flagged as overflowed. After the point marked
// i_last_point, the stored set is streamed out, each result read and then
// output in turn and shown for exactly one cycle with o_strobe high;
// o_last_out marks the final one and o_overflowed is set on every result of a
// flagged set. After the last point is placed or dropped, the controller passes
// through S_FIN, S_ERD and S_EOUT, and each result is registered before it is
// shown. busy drops in the cycle the final result is shown. Results cannot be
// held off. Reset empties the store at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module point_sort_by_x #(
    parameter int MAX_POINTS = psx_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = psx_pkg::COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [COORD_BITS-1:0] i_point_x,
    input  logic signed [COORD_BITS-1:0] i_point_y,
    input  logic                         i_last_point,
    output logic                         o_strobe,
    output logic signed [COORD_BITS-1:0] o_sorted_x,
    output logic signed [COORD_BITS-1:0] o_sorted_y,
    output logic                         o_last_out,
    output logic                         o_overflowed
);

    psx_pkg::t_cmd    cmd;
    psx_pkg::t_status st;

    psx_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_st    (st),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    psx_dp #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_point_x    (i_point_x),
        .i_point_y    (i_point_y),
        .i_last_point (i_last_point),
        .o_st         (st),
        .o_strobe     (o_strobe),
        .o_sorted_x   (o_sorted_x),
        .o_sorted_y   (o_sorted_y),
        .o_last_out   (o_last_out),
        .o_overflowed (o_overflowed)
    );

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted request did not raise busy");

    a_strobe_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("result strobe without prior activity");

    a_results_spaced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("back-to-back result strobes");

    a_last_ends_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_last_out |-> busy)
        else $error("controller idle before final result");

endmodule

FILE: hw/rtl/psx_ctrl.sv
// ----------------------------------------------------------------------------
// psx_ctrl
// Sequencer for insertion and readout of the point store.
// ----------------------------------------------------------------------------
module psx_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  psx_pkg::t_status i_st,
    output psx_pkg::t_cmd    o_cmd,
    output logic             o_busy
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_INS  = 6'b000010,
        S_CMP  = 6'b000100,
        S_FIN  = 6'b001000,
        S_ERD  = 6'b010000,
        S_EOUT = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_INS;
                end
            end
            S_INS: begin
                if (i_st.full) begin
                    n_state = S_FIN;
                end else if (i_st.pos_zero) begin
                    o_cmd.place = 1'b1;
                    n_state     = S_FIN;
                end else begin
                    o_cmd.rd_prev = 1'b1;
                    n_state       = S_CMP;
                end
            end
            S_CMP: begin
                if (i_st.prev_gt) begin
                    o_cmd.shift = 1'b1;
                    n_state     = S_INS;
                end else begin
                    o_cmd.place = 1'b1;
                    n_state     = S_FIN;
                end
            end
            S_FIN: begin
                if (i_st.last) begin
                    o_cmd.emit_start = 1'b1;
                    n_state          = S_ERD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_ERD: begin
                o_cmd.emit_rd = 1'b1;
                n_state       = S_EOUT;
            end
            S_EOUT: begin
                o_cmd.emit_out = 1'b1;
                if (i_st.emit_done) begin
                    o_cmd.clear = 1'b1;
                    n_state     = S_IDLE;
                end else begin
                    n_state = S_ERD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

FILE: hw/rtl/psx_dp.sv
// ----------------------------------------------------------------------------
// psx_dp
// Point store, insert position, fill count and result registers.
// ----------------------------------------------------------------------------
module psx_dp #(
    parameter int MAX_POINTS = psx_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = psx_pkg::COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  psx_pkg::t_cmd                i_cmd,
    input  logic signed [COORD_BITS-1:0] i_point_x,
    input  logic signed [COORD_BITS-1:0] i_point_y,
    input  logic                         i_last_point,
    output psx_pkg::t_status             o_st,
    output logic                         o_strobe,
    output logic signed [COORD_BITS-1:0] o_sorted_x,
    output logic signed [COORD_BITS-1:0] o_sorted_y,
    output logic                         o_last_out,
    output logic                         o_overflowed
);

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int DW = 2 * COORD_BITS;

    logic [DW-1:0] mem [MAX_POINTS];

    logic [DW-1:0]                r_rd_data;
    logic signed [COORD_BITS-1:0] r_key_x;
    logic signed [COORD_BITS-1:0] r_key_y;
    logic                         r_last;
    logic [CW-1:0]                r_pos;
    logic [CW-1:0]                r_count;
    logic [CW-1:0]                r_idx;
    logic                         r_ovf;
    logic                         r_out_vld;
    logic signed [COORD_BITS-1:0] r_out_x;
    logic signed [COORD_BITS-1:0] r_out_y;
    logic                         r_out_last;
    logic                         r_out_ovf;

    logic [CW-1:0] pos_m1;
    logic [AW-1:0] rd_addr;
    logic          rd_en;
    logic          wr_en;
    logic [DW-1:0] wr_data;
    logic          full;

    assign pos_m1  = r_pos - CW'(1);
    assign full    = (r_count == CW'(MAX_POINTS));
    assign rd_en   = i_cmd.rd_prev | i_cmd.emit_rd;
    assign rd_addr = i_cmd.emit_rd ? r_idx[AW-1:0] : pos_m1[AW-1:0];
    assign wr_en   = i_cmd.shift | i_cmd.place;
    assign wr_data = i_cmd.shift ? r_rd_data : {r_key_x, r_key_y};

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_pos[AW-1:0]] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key_x <= i_point_x;
            r_key_y <= i_point_y;
            r_last  <= i_last_point;
        end
        if (i_cmd.emit_out) begin
            r_out_x    <= r_rd_data[DW-1:COORD_BITS];
            r_out_y    <= r_rd_data[COORD_BITS-1:0];
            r_out_last <= (r_idx == r_count);
            r_out_ovf  <= r_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_count   <= '0;
            r_idx     <= '0;
            r_ovf     <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= i_cmd.emit_out;
            if (i_cmd.load) begin
                r_pos <= r_count;
                if (full) begin
                    r_ovf <= 1'b1;
                end
            end else if (i_cmd.shift) begin
                r_pos <= pos_m1;
            end
            if (i_cmd.place) begin
                r_count <= r_count + CW'(1);
            end
            if (i_cmd.emit_start) begin
                r_idx <= '0;
            end else if (i_cmd.emit_rd) begin
                r_idx <= r_idx + CW'(1);
            end
            if (i_cmd.clear) begin
                r_count <= '0;
                r_ovf   <= 1'b0;
            end
        end
    end

    assign o_st.full      = full;
    assign o_st.pos_zero  = (r_pos == '0);
    assign o_st.prev_gt   = ($signed(r_rd_data[DW-1:COORD_BITS]) > r_key_x);
    assign o_st.last      = r_last;
    assign o_st.emit_done = (r_idx == r_count);

    assign o_strobe     = r_out_vld;
    assign o_sorted_x   = r_out_x;
    assign o_sorted_y   = r_out_y;
    assign o_last_out   = r_out_last;
    assign o_overflowed = r_out_ovf;

endmodule

FILE: bench/tb_point_sort_by_x.sv
// ----------------------------------------------------------------------------
// tb_point_sort_by_x
// Self-checking bench for the point sorter. Point sets are fed through the
// start/busy request port. A predictor keeps its own sorted store, stable
// for equal x, and queues the sorted points that each final point releases.
// Every strobed result is compared field by field with the oldest queued
// point. Covered: coordinate extremes, ties, presorted and reversed sets, and
// a set that fills the store and then overflows it.
// ----------------------------------------------------------------------------
module tb_point_sort_by_x;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_PTS    = psx_pkg::MAX_POINTS_DEF;
    localparam int CBITS      = psx_pkg::COORD_BITS_DEF;
    localparam int CYCLE_CAP  = 400000;
    localparam int TAIL_WAIT  = 2 * MAX_PTS + 10;
    localparam int SHOW_LIMIT = 10;
    localparam int NUM_ITEMS  = 100;

    typedef logic signed [CBITS-1:0] t_coord;

    typedef struct {
        t_coord      x;
        t_coord      y;
        logic        last;
        int unsigned gap_pct;
        bit          drain_first;
    } t_point_req;

    typedef struct {
        t_coord x;
        t_coord y;
        logic   last;
        logic   ovf;
    } t_sorted_pt;

    logic   i_clk = 1'b0;
    logic   i_rst_n = 1'b0;
    logic   start = 1'b0;
    logic   busy;
    t_coord i_point_x = '0;
    t_coord i_point_y = '0;
    logic   i_last_point = 1'b0;
    logic   o_strobe;
    t_coord o_sorted_x;
    t_coord o_sorted_y;
    logic   o_last_out;
    logic   o_overflowed;

    t_point_req pending_points[$];
    t_point_req point_on_port;
    t_sorted_pt sorted_expected[$];

    // predictor copy of the block's store
    t_coord      model_x[MAX_PTS];
    t_coord      model_y[MAX_PTS];
    int unsigned model_count = 0;
    logic        model_ovf = 1'b0;

    int unsigned results_predicted = 0;
    int unsigned results_seen = 0;
    int unsigned points_accepted = 0;
    int unsigned sets_done = 0;
    int unsigned ovf_sets = 0;
    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;

    point_sort_by_x dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_point_x    (i_point_x),
        .i_point_y    (i_point_y),
        .i_last_point (i_last_point),
        .o_strobe     (o_strobe),
        .o_sorted_x   (o_sorted_x),
        .o_sorted_y   (o_sorted_y),
        .o_last_out   (o_last_out),
        .o_overflowed (o_overflowed)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Insert the point behind every stored point with x <= its own (drop it and
    // flag overflow if full); a final point releases the whole sorted set.
    task automatic sort_in_point(input t_point_req req);
        int unsigned pos;
        t_sorted_pt  res;
        if (model_count < MAX_PTS) begin
            pos = model_count;
            while (pos > 0 && model_x[pos-1] > req.x) begin
                model_x[pos] = model_x[pos-1];
                model_y[pos] = model_y[pos-1];
                pos--;
            end
            model_x[pos] = req.x;
            model_y[pos] = req.y;
            model_count++;
        end else begin
            model_ovf = 1'b1;
        end
        if (req.last) begin
            for (int unsigned i = 0; i < model_count; i++) begin
                res.x    = model_x[i];
                res.y    = model_y[i];
                res.last = (i + 1 == model_count);
                res.ovf  = model_ovf;
                sorted_expected.push_back(res);
            end
            results_predicted <= results_predicted + model_count;
            sets_done++;
            if (model_ovf)
                ovf_sets++;
            model_count = 0;
            model_ovf   = 1'b0;
        end
    endtask

    // Driver: one nonblocking update of start per edge.
    always @(posedge i_clk) begin
        logic drive;
        logic took;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            drive = start;
            took  = 1'b0;
            if (start && !busy) begin
                sort_in_point(point_on_port);
                points_accepted++;
                drive = 1'b0;
                took  = 1'b1;
            end
            if (!drive && pending_points.size() > 0) begin
                // hold a drain-first request until every sorted point is back
                if (!(pending_points[0].drain_first &&
                      (took || results_seen != results_predicted)) &&
                    $urandom_range(99) >= pending_points[0].gap_pct) begin
                    point_on_port = pending_points.pop_front();
                    i_point_x    <= point_on_port.x;
                    i_point_y    <= point_on_port.y;
                    i_last_point <= point_on_port.last;
                    drive = 1'b1;
                end
            end
            start <= drive;
        end
    end

    // Monitor: results cannot be stalled, so check each strobe as it comes.
    always @(posedge i_clk) begin
        t_sorted_pt want;
        if (i_rst_n === 1'b1 && o_strobe === 1'b1) begin
            results_seen <= results_seen + 1;
            if (sorted_expected.size() == 0) begin
                mismatches++;
                if (mismatches <= SHOW_LIMIT)
                    $display("%0t: unexpected result x=%0d y=%0d last=%b ovf=%b",
                             $realtime, o_sorted_x, o_sorted_y, o_last_out,
                             o_overflowed);
            end else begin
                want = sorted_expected.pop_front();
                if (o_sorted_x !== want.x || o_sorted_y !== want.y ||
                    o_last_out !== want.last || o_overflowed !== want.ovf) begin
                    mismatches++;
                    if (mismatches <= SHOW_LIMIT)
                        $display("%0t: mismatch exp %0d/%0d/%b/%b got %0d/%0d/%b/%b",
                                 $realtime, want.x, want.y, want.last, want.ovf,
                                 o_sorted_x, o_sorted_y, o_last_out, o_overflowed);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_CAP) begin
            $display("timeout after %0d cycles, %0d sorted points outstanding",
                     cycle_count, sorted_expected.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic queue_point(input t_coord x, input t_coord y, input logic last,
                               input int unsigned gap, input bit drain);
        t_point_req req;
        req.x           = x;
        req.y           = y;
        req.last        = last;
        req.gap_pct     = gap;
        req.drain_first = drain;
        pending_points.push_back(req);
    endtask

    // Sender idle rate by position in the run: 20%, then 75%, then none.
    function automatic int unsigned phase_gap(input int unsigned idx);
        if (idx < 33)
            return 20;
        if (idx < 66)
            return 75;
        return 0;
    endfunction

    // Mix narrow keys (many ties), extremes and full-range values.
    function automatic t_coord pick_x();
        int v;
        v = $urandom_range(8);
        case ($urandom_range(3))
            0: return t_coord'(v - 4);
            1: begin
                case ($urandom_range(3))
                    0: return {1'b1, {(CBITS-1){1'b0}}};
                    1: return {1'b0, {(CBITS-1){1'b1}}};
                    2: return '1;
                    default: return '0;
                endcase
            end
            default: return t_coord'($urandom);
        endcase
    endfunction

    task automatic queue_random_set(input int unsigned n, input bit drain);
        for (int unsigned i = 0; i < n; i++)
            queue_point(pick_x(), t_coord'($urandom), i + 1 == n,
                        phase_gap(pending_points.size()), drain && i == 0);
    endtask

    initial begin
        int unsigned n;
        bit          drain;
        bit          big_ovf_done;

        // single point at the extremes
        queue_point(16'sh8000, 16'sh7fff, 1'b1, 20, 1'b0);
        // extremes with ties at 0 and at the top value
        queue_point(16'sh7fff, 16'sh8000, 1'b0, 20, 1'b0);
        queue_point(16'sh0000, 16'sh5555, 1'b0, 20, 1'b0);
        queue_point(16'sh8000, 16'sh2aaa, 1'b0, 20, 1'b0);
        queue_point(16'sh0000, 16'sh0001, 1'b0, 20, 1'b0);
        queue_point(16'shffff, 16'shffff, 1'b0, 20, 1'b0);
        queue_point(16'sh7fff, 16'sh0002, 1'b0, 20, 1'b0);
        queue_point(16'sh0001, 16'sh0000, 1'b1, 20, 1'b0);
        // already in order
        queue_point(-16'sd3, 16'sd0, 1'b0, 20, 1'b0);
        queue_point(-16'sd2, 16'sd0, 1'b0, 20, 1'b0);
        queue_point(-16'sd1, 16'sd0, 1'b1, 20, 1'b0);
        // reversed: every insert walks the whole store
        queue_point(16'sd5, 16'sd10, 1'b0, 20, 1'b0);
        queue_point(16'sd4, 16'sd11, 1'b0, 20, 1'b0);
        queue_point(16'sd3, 16'sd12, 1'b0, 20, 1'b0);
        queue_point(16'sd2, 16'sd13, 1'b1, 20, 1'b0);
        // all keys equal
        queue_point(16'sd7, 16'sd1, 1'b0, 20, 1'b0);
        queue_point(16'sd7, 16'sd2, 1'b0, 20, 1'b0);
        queue_point(16'sd7, 16'sd3, 1'b1, 20, 1'b0);

        big_ovf_done = 1'b0;
        while (pending_points.size() < NUM_ITEMS) begin
            drain = (pending_points.size() >= 33 && pending_points.size() < 45);
            if (!big_ovf_done && pending_points.size() >= 24) begin
                // store fills exactly, then later points including the final one drop
                queue_random_set(MAX_PTS + 1 + $urandom_range(2), 1'b1);
                big_ovf_done = 1'b1;
            end else begin
                n = $urandom_range(1, 12);
                queue_random_set(n, drain);
            end
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_points.size() != 0 || start ||
               results_seen != results_predicted)
            @(negedge i_clk);
        repeat (TAIL_WAIT) @(negedge i_clk);

        $display("covered %0d sets (%0d overflowed) from %0d accepted points",
                 sets_done, ovf_sets, points_accepted);
        $display("checked %0d sorted points, %0d mismatches",
                 results_seen, mismatches);
        if (mismatches == 0 && sorted_expected.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/psx_pkg.sv
hw/rtl/psx_ctrl.sv
hw/rtl/psx_dp.sv
hw/rtl/point_sort_by_x.sv
bench/tb_point_sort_by_x.sv
